// ===== rtl/cme_pkg.sv =====
// shared constants and types for the chained modular exponentiation cipher
package cme_pkg;

    localparam int MOD_W     = 16;
    localparam int EXP_W     = 16;
    localparam int DATA_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PUB_EXP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIV_EXP = 2'd2;

    localparam logic [MOD_W-1:0] MODULUS_RST  = MOD_W'(3233);
    localparam logic [EXP_W-1:0] PUB_EXP_RST  = EXP_W'(17);
    localparam logic [EXP_W-1:0] PRIV_EXP_RST = EXP_W'(2753);

    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    typedef struct packed {
        logic             start;
        logic [MOD_W-1:0] a;
        logic [MOD_W-1:0] b;
    } t_mm_req;

    typedef struct packed {
        logic             done;
        logic [MOD_W-1:0] prod;
    } t_mm_rsp;

endpackage

// ===== rtl/cme_in_if.sv =====
// input channel: valid/ready with mode, data and chain start flag
interface cme_in_if;
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic [cme_pkg::DATA_W-1:0] data_in;
    logic                       chain_start;

    modport source (output valid, output mode, output data_in, output chain_start,
                    input ready);
    modport sink   (input valid, input mode, input data_in, input chain_start,
                    output ready);
endinterface

// ===== rtl/cme_out_if.sv =====
// output channel: valid/ready with the result word
interface cme_out_if;
    logic                       valid;
    logic                       ready;
    logic [cme_pkg::DATA_W-1:0] data_out;

    modport source (output valid, output data_out, input ready);
    modport sink   (input valid, input data_out, output ready);
endinterface

// ===== rtl/cme_modmul.sv =====
// bit-serial interleaved modular multiplier, one multiplier bit per cycle
module cme_modmul (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [cme_pkg::MOD_W-1:0] i_mod,
    input  cme_pkg::t_mm_req        i_req,
    output cme_pkg::t_mm_rsp        o_rsp
);
    import cme_pkg::*;

    localparam int CNT_W = $clog2(MOD_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [MOD_W-1:0]   r_a;
    logic [MOD_W-1:0]   r_b;
    logic [MOD_W-1:0]   r_acc;
    logic [MOD_W-1:0]   n_acc;
    logic [MOD_W+1:0]   part_sum;
    logic [MOD_W+1:0]   mod_x1;
    logic [MOD_W+1:0]   mod_x2;

    // acc < n and b < n keep the partial sum below 3n
    always_comb begin
        mod_x1   = {2'b00, i_mod};
        mod_x2   = {1'b0, i_mod, 1'b0};
        part_sum = {1'b0, r_acc, 1'b0} + (r_a[MOD_W-1] ? {2'b00, r_b} : '0);
        if (part_sum >= mod_x2) begin
            n_acc = MOD_W'(part_sum - mod_x2);
        end else if (part_sum >= mod_x1) begin
            n_acc = MOD_W'(part_sum - mod_x1);
        end else begin
            n_acc = MOD_W'(part_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MOD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_a   <= {r_a[MOD_W-2:0], 1'b0};
            r_acc <= n_acc;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;

endmodule

// ===== rtl/cbc_chained_modexp_cipher.sv =====
// top level: cbc-chained byte cipher by square-and-multiply modular exponentiation
//
// One item at a time. After acceptance the base is reduced mod n (one modular
// multiply by 1), then for each of the 16 exponent bits, lsb first, a multiply
// into the accumulator when the bit is set and a squaring. Each modular multiply
// runs in the shared bit-serial multiplier; the squaring after a multiply is
// issued in the cycle the multiply finishes. The result is registered in the
// finish state once the output is free, and the next item can be accepted from
// the cycle the result is presented. A modulus below 2 skips the exponentiation
// (which then yields 0) and goes from acceptance straight to the finish state.
// Encrypt returns the ciphertext word and takes its low byte as the chain byte;
// decrypt returns the recovered byte xor the chain byte and takes the low byte
// of the input word. chain_start clears the chain byte before the item.
// Configuration writes must only happen while no item is in progress.
module cbc_chained_modexp_cipher (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cme_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cme_pkg::CFG_W-1:0]     i_cfg_data,
    cme_in_if.sink                        i_in,
    cme_out_if.source                     o_out
);
    import cme_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RED  = 3'd1;
    localparam logic [2:0] ST_STEP = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_SQR  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    localparam int BC_W = $clog2(EXP_W + 1);

    logic [MOD_W-1:0]  r_mod;
    logic [EXP_W-1:0]  r_pub;
    logic [EXP_W-1:0]  r_priv;
    logic [2:0]        r_state;
    logic [BYTE_W-1:0] r_chain;
    logic              r_mode;
    logic [BYTE_W-1:0] r_in_lo;
    logic [EXP_W-1:0]  r_exp;
    logic [BC_W-1:0]   r_bitcnt;
    logic [MOD_W-1:0]  r_acc;
    logic [MOD_W-1:0]  r_sq;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out;

    logic              in_fire;
    logic              out_free;
    logic [BYTE_W-1:0] chain_eff;
    logic [MOD_W-1:0]  base;
    t_mm_req           mm_req;
    t_mm_rsp           mm_rsp;

    assign in_fire   = i_in.valid && i_in.ready;
    assign out_free  = !r_out_valid || o_out.ready;
    assign chain_eff = i_in.chain_start ? '0 : r_chain;
    assign base      = (i_in.mode == MODE_ENC)
                     ? MOD_W'(i_in.data_in[BYTE_W-1:0] ^ chain_eff)
                     : MOD_W'(i_in.data_in);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod  <= MODULUS_RST;
            r_pub  <= PUB_EXP_RST;
            r_priv <= PRIV_EXP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODULUS:  r_mod  <= MOD_W'(i_cfg_data);
                CFG_PUB_EXP:  r_pub  <= EXP_W'(i_cfg_data);
                CFG_PRIV_EXP: r_priv <= EXP_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // multiplier issue
    always_comb begin
        mm_req.start = 1'b0;
        mm_req.a     = r_sq;
        mm_req.b     = r_sq;
        if (r_state == ST_IDLE) begin
            mm_req.start = in_fire && (r_mod >= MOD_W'(2));
            mm_req.a     = base;
            mm_req.b     = MOD_W'(1);
        end else if (r_state == ST_STEP) begin
            mm_req.start = (r_bitcnt != BC_W'(EXP_W));
            mm_req.a     = r_exp[0] ? r_acc : r_sq;
        end else if (r_state == ST_MUL) begin
            mm_req.start = mm_rsp.done;
        end
    end

    cme_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mod   (r_mod),
        .i_req   (mm_req),
        .o_rsp   (mm_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_chain     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_chain <= chain_eff;
                        r_state <= (r_mod >= MOD_W'(2)) ? ST_RED : ST_FIN;
                    end
                end
                ST_RED: begin
                    if (mm_rsp.done) r_state <= ST_STEP;
                end
                ST_STEP: begin
                    if (r_bitcnt == BC_W'(EXP_W)) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_state <= r_exp[0] ? ST_MUL : ST_SQR;
                    end
                end
                ST_MUL: begin
                    if (mm_rsp.done) r_state <= ST_SQR;
                end
                ST_SQR: begin
                    if (mm_rsp.done) r_state <= ST_STEP;
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_chain     <= (r_mode == MODE_ENC) ? r_acc[BYTE_W-1:0] : r_in_lo;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && in_fire) begin
            r_mode   <= i_in.mode;
            r_in_lo  <= i_in.data_in[BYTE_W-1:0];
            r_exp    <= (i_in.mode == MODE_ENC) ? r_pub : r_priv;
            r_bitcnt <= '0;
            r_acc    <= (r_mod >= MOD_W'(2)) ? MOD_W'(1) : '0;
        end
        if (r_state == ST_RED && mm_rsp.done) begin
            r_sq <= mm_rsp.prod;
        end
        if (r_state == ST_MUL && mm_rsp.done) begin
            r_acc <= mm_rsp.prod;
        end
        if (r_state == ST_SQR && mm_rsp.done) begin
            r_sq     <= mm_rsp.prod;
            r_exp    <= r_exp >> 1;
            r_bitcnt <= r_bitcnt + 1'b1;
        end
        if (r_state == ST_FIN && out_free) begin
            r_out <= (r_mode == MODE_ENC) ? DATA_W'(r_acc)
                                          : DATA_W'(r_acc[BYTE_W-1:0] ^ r_chain);
        end
    end

    assign i_in.ready     = (r_state == ST_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.data_out = r_out;

`ifndef SYNTHESIS
    a_done_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mm_rsp.done |-> (r_state == ST_RED || r_state == ST_MUL || r_state == ST_SQR))
        else $error("multiplier finished outside a compute state");

    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && r_mod >= MOD_W'(2)) |-> (r_acc < r_mod))
        else $error("accumulator not reduced below modulus");

    a_bitcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STEP || r_state == ST_MUL || r_state == ST_SQR)
        |-> (r_bitcnt <= BC_W'(EXP_W)))
        else $error("exponent bit counter out of range");

    a_fin_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && out_free) |=> r_out_valid)
        else $error("finished result not presented");
`endif

endmodule

// ===== sim/tb_cbc_chained_modexp_cipher.sv =====
// testbench for the cbc-chained modular exponentiation cipher with self-checking predictor
`timescale 1ns / 1ps

module tb_cbc_chained_modexp_cipher;
    import cme_pkg::*;

    typedef struct packed {
        logic              mode;
        logic [DATA_W-1:0] data;
        logic              start;
    } t_cipher_beat;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    cme_in_if  in_ch ();
    cme_out_if out_ch ();

    cbc_chained_modexp_cipher dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    t_cipher_beat      beats_to_send[$];
    logic [DATA_W-1:0] words_due[$];

    // predictor copy of key registers and chain byte
    logic [MOD_W-1:0]  key_n;
    logic [EXP_W-1:0]  key_e;
    logic [EXP_W-1:0]  key_d;
    logic [BYTE_W-1:0] link_byte;

    int send_idle_pct;
    int recv_idle_pct;
    int fail_count;

    always #4 i_clk = ~i_clk;

    function automatic logic [MOD_W-1:0] powmod16(input logic [MOD_W-1:0] base,
                                                  input logic [EXP_W-1:0] e,
                                                  input logic [MOD_W-1:0] n);
        longint unsigned acc;
        longint unsigned sq;
        longint unsigned nn;
        nn = 64'(n);
        if (nn < 2)
            return '0;
        sq  = 64'(base) % nn;
        acc = 1 % nn;
        for (int k = 0; k < EXP_W; k++) begin
            if (e[k])
                acc = (acc * sq) % nn;
            sq = (sq * sq) % nn;
        end
        return acc[MOD_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] cipher_predict(input t_cipher_beat b);
        logic [MOD_W-1:0] r;
        if (b.start)
            link_byte = '0;
        if (b.mode == MODE_ENC) begin
            r = powmod16({8'h00, b.data[7:0] ^ link_byte}, key_e, key_n);
            link_byte = r[7:0];
            return r;
        end
        r = powmod16(b.data, key_d, key_n);
        r = {8'h00, r[7:0] ^ link_byte};
        link_byte = b.data[7:0];
        return r;
    endfunction

    // driver: predicts on each accepted beat, then presents the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                words_due.push_back(cipher_predict({in_ch.mode, in_ch.data_in,
                                                    in_ch.chain_start}));
            if (!in_ch.valid || in_ch.ready) begin
                if (beats_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    t_cipher_beat nb;
                    nb = beats_to_send.pop_front();
                    in_ch.valid       <= 1'b1;
                    in_ch.mode        <= nb.mode;
                    in_ch.data_in     <= nb.data;
                    in_ch.chain_start <= nb.start;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result beat with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (words_due.size() == 0) begin
                    $error("data_out beat with nothing expected: got %h", out_ch.data_out);
                    fail_count++;
                end else begin
                    logic [DATA_W-1:0] want;
                    want = words_due.pop_front();
                    if (out_ch.data_out !== want) begin
                        $error("data_out mismatch: expected %h, got %h", want,
                               out_ch.data_out);
                        fail_count++;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic set_keys(input logic [15:0] n, input logic [15:0] e,
                            input logic [15:0] d);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_MODULUS;
        cfg_data <= n;
        @(posedge i_clk);
        cfg_idx  <= CFG_PUB_EXP;
        cfg_data <= e;
        @(posedge i_clk);
        cfg_idx  <= CFG_PRIV_EXP;
        cfg_data <= d;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        key_n = n;
        key_e = e;
        key_d = d;
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (beats_to_send.size() != 0 || in_ch.valid || words_due.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic push_beat(input logic mode, input logic [15:0] data, input logic start);
        beats_to_send.push_back(t_cipher_beat'{mode: mode, data: data, start: start});
    endtask

    // encrypt a run of bytes, then decrypt the ciphertexts, each run from the zero iv
    task automatic push_round_trip(input int len);
        logic [DATA_W-1:0] ct[$];
        logic [BYTE_W-1:0] chn;
        logic [BYTE_W-1:0] pt;
        logic [MOD_W-1:0]  c;
        chn = '0;
        for (int k = 0; k < len; k++) begin
            pt  = 8'($urandom_range(255));
            c   = powmod16({8'h00, pt ^ chn}, key_e, key_n);
            chn = c[7:0];
            ct.push_back(c);
            push_beat(MODE_ENC, {8'h00, pt}, k == 0);
        end
        for (int k = 0; k < len; k++)
            push_beat(MODE_DEC, ct[k], k == 0);
    endtask

    task automatic push_random_chunk(input int count);
        int pushed;
        int len;
        pushed = 0;
        while (pushed < count) begin
            if ($urandom_range(3) != 0) begin
                len = $urandom_range(1, 6);
                push_round_trip(len);
                pushed += 2 * len;
            end else begin
                push_beat(1'($urandom_range(1)), 16'($urandom_range(65535)),
                          $urandom_range(7) == 0);
                pushed++;
            end
        end
    endtask

    initial begin
        #30_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        logic [15:0] cn;
        logic [15:0] ce;
        logic [15:0] cd;
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = CFG_MODULUS;
        cfg_data          = '0;
        in_ch.valid       = 1'b0;
        in_ch.mode        = MODE_ENC;
        in_ch.data_in     = '0;
        in_ch.chain_start = 1'b0;
        out_ch.ready      = 1'b0;
        key_n             = MODULUS_RST;
        key_e             = PUB_EXP_RST;
        key_d             = PRIV_EXP_RST;
        link_byte         = '0;
        fail_count        = 0;
        send_idle_pct     = 20;
        recv_idle_pct     = 80;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset keys: byte extremes, wide plaintext, ciphertext at and above modulus
        push_beat(MODE_ENC, 16'h0000, 1'b1);
        push_beat(MODE_ENC, 16'h00ff, 1'b0);
        push_beat(MODE_ENC, 16'hff00, 1'b0);
        push_beat(MODE_ENC, 16'hffff, 1'b0);
        push_beat(MODE_ENC, 16'h1234, 1'b1);
        push_beat(MODE_DEC, 16'h0000, 1'b1);
        push_beat(MODE_DEC, 16'd3232, 1'b0);
        push_beat(MODE_DEC, 16'd3233, 1'b0);
        push_beat(MODE_DEC, 16'hffff, 1'b0);
        push_beat(MODE_DEC, 16'haaaa, 1'b1);
        wait_idle();

        // degenerate moduli
        set_keys(16'd0, 16'd17, 16'd2753);
        push_beat(MODE_ENC, 16'h0055, 1'b0);
        push_beat(MODE_DEC, 16'h5555, 1'b0);
        wait_idle();
        set_keys(16'd1, 16'd17, 16'd2753);
        push_beat(MODE_ENC, 16'h00aa, 1'b1);
        push_beat(MODE_DEC, 16'h1234, 1'b0);
        wait_idle();

        // zero exponents
        set_keys(16'd3233, 16'd0, 16'd0);
        push_beat(MODE_ENC, 16'h00c3, 1'b1);
        push_beat(MODE_DEC, 16'h0bad, 1'b0);
        wait_idle();

        // everything at the top
        set_keys(16'hffff, 16'hffff, 16'hffff);
        push_beat(MODE_ENC, 16'hffff, 1'b0);
        push_beat(MODE_DEC, 16'hffff, 1'b0);
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin cn = 16'd3233;  ce = 16'd17;    cd = 16'd2753;  end
                1: begin cn = 16'd143;   ce = 16'd7;     cd = 16'd103;   end
                2: begin cn = 16'hffff;  ce = 16'hffff;  cd = 16'hffff;  end
                3: begin cn = 16'd55;    ce = 16'd3;     cd = 16'd27;    end
                4: begin cn = 16'd2;     ce = 16'd1;     cd = 16'd0;     end
                5: begin
                    cn = 16'($urandom_range(2, 65535));
                    ce = 16'($urandom_range(65535));
                    cd = 16'($urandom_range(65535));
                end
                6: begin cn = 16'd65521; ce = 16'($urandom_range(65535)); cd = 16'd1; end
                default: begin cn = 16'd3233; ce = 16'd17; cd = 16'd2753; end
            endcase
            if (ph < 3) begin
                send_idle_pct = 20;
                recv_idle_pct = 80;
            end else if (ph < 6) begin
                send_idle_pct = 80;
                recv_idle_pct = 20;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_keys(cn, ce, cd);
            push_random_chunk(125);
            wait_idle();
        end

        repeat (20) @(negedge i_clk);
        if (fail_count == 0 && words_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/cme_pkg.sv
rtl/cme_in_if.sv
rtl/cme_out_if.sv
rtl/cme_modmul.sv
rtl/cbc_chained_modexp_cipher.sv
sim/tb_cbc_chained_modexp_cipher.sv
